// ===== hw/rtl/afs_pkg.sv =====
package afs_pkg;

  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;
  // The divider takes a dividend one bit wider than a time value, so that
  // frame plus jump fits without loss.
  localparam int unsigned DIV_W    = TIME_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [FRAME_W-1:0] RESET_INTERVAL = FRAME_W'(83);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 4'd0,
    CMD_PLAY   = 4'd1,
    CMD_STOP   = 4'd2,
    CMD_TOGGLE = 4'd3,
    CMD_NEXT   = 4'd4,
    CMD_PREV   = 4'd5,
    CMD_START  = 4'd6,
    CMD_END    = 4'd7,
    CMD_SET    = 4'd8
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL = 2'd0,
    REG_COUNT    = 2'd1,
    REG_LOOP     = 2'd2
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_DIV1   = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_DIV2   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_sel_count;
    logic save_div1;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_play;
    logic div_done;
    logic need_div2;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/afs_div.sv =====
module afs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [afs_pkg::DIV_W-1:0]      dividend_i,
  input  logic [afs_pkg::FRAME_W-1:0]    divisor_i,
  output logic [afs_pkg::DIV_W-1:0]      quo_o,
  output logic [afs_pkg::FRAME_W-1:0]    rem_o,
  output logic                           done_o
);

  logic [afs_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [afs_pkg::FRAME_W-1:0]   rem_q, rem_d;
  logic [afs_pkg::FRAME_W-1:0]   dvs_q, dvs_d;
  logic [afs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [afs_pkg::FRAME_W:0]     trial;
  logic                          fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_q, quo_q[afs_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = afs_pkg::DIV_CNT_W'(afs_pkg::DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? afs_pkg::FRAME_W'(trial - {1'b0, dvs_q})
                   : trial[afs_pkg::FRAME_W-1:0];
      quo_d = {quo_q[afs_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == afs_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && cnt_q == '0))
    else $error("divider reported done with steps left");

endmodule

// ===== hw/rtl/afs_datapath.sv =====
module afs_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [afs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [afs_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [afs_pkg::CMD_W-1:0]         in_cmd_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [afs_pkg::OUT_DATA_W-1:0]    out_data_o,
  input  afs_pkg::ctrl_cmd_t                ctrl_i,
  output afs_pkg::dp_status_t               status_o
);

  localparam int unsigned FW = afs_pkg::FRAME_W;
  localparam int unsigned TW = afs_pkg::TIME_W;

  // Configuration registers.
  logic [FW-1:0] interval_q, count_q;
  logic          loop_q;

  // Sequencer state.
  logic [FW-1:0] frame_q, frame_d;
  logic          play_q, play_d;
  logic [TW-1:0] origin_q, origin_d;
  logic [TW-1:0] wanted_q, wanted_d;

  // Captured command.
  logic [afs_pkg::CMD_W-1:0] cmd_q;
  logic [TW-1:0]             now_q;
  logic [FW-1:0]             target_q;

  // Results of the first division.
  logic [TW-1:0] jump_q;
  logic [FW-1:0] rem1_q;
  logic          jump_zero_q, past_q;

  logic                 out_valid_q;
  logic [FW-1:0]        out_frame_q;
  logic                 out_play_q, out_adv_q, out_chg_q;
  logic                 adv, chg;

  logic [FW-1:0]        interval_eff, count_eff, last;
  logic [TW-1:0]        elapsed, delta;
  logic [afs_pkg::DIV_W-1:0] div_dividend, div_quo, frame_plus_jump;
  logic [FW-1:0]        div_divisor, div_rem;
  logic                 div_done;
  logic                 past;
  logic                 out_free;

  assign interval_eff = (interval_q == '0) ? FW'(1) : interval_q;
  assign count_eff    = (count_q == '0) ? FW'(1) : count_q;
  assign last         = count_eff - 1'b1;

  assign elapsed = now_q - origin_q;
  assign delta   = elapsed - wanted_q;
  assign frame_plus_jump = {1'b0, jump_q} + afs_pkg::DIV_W'(frame_q);

  assign div_dividend = ctrl_i.div_sel_count ? frame_plus_jump : {1'b0, delta};
  assign div_divisor  = ctrl_i.div_sel_count ? count_eff : interval_eff;

  afs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // The end is reached when the frame is already out of range or the jump
  // covers the frames left.
  assign past = (frame_q >= count_eff) ||
                (div_quo[TW-1:0] >= TW'(count_eff - frame_q));

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    frame_d  = frame_q;
    play_d   = play_q;
    origin_d = origin_q;
    wanted_d = wanted_q;
    adv      = 1'b0;
    chg      = 1'b0;
    case (cmd_q)
      afs_pkg::CMD_TICK: begin
        if (play_q && !jump_zero_q) begin
          if (past_q && !loop_q) begin
            play_d = 1'b0;
            chg    = 1'b1;
          end else begin
            frame_d  = past_q ? div_rem : FW'(frame_q + jump_q[FW-1:0]);
            adv      = 1'b1;
            // Scheduled time moves by jump * interval, which is delta less rem.
            wanted_d = elapsed - TW'(rem1_q);
          end
        end
      end
      afs_pkg::CMD_PLAY, afs_pkg::CMD_STOP, afs_pkg::CMD_TOGGLE: begin
        if (play_q && cmd_q != afs_pkg::CMD_PLAY) begin
          play_d = 1'b0;
          chg    = 1'b1;
        end else if (!play_q && cmd_q != afs_pkg::CMD_STOP) begin
          if (frame_q == last) begin
            frame_d = '0;
          end
          play_d   = 1'b1;
          origin_d = now_q;
          wanted_d = '0;
          chg      = 1'b1;
        end
      end
      afs_pkg::CMD_NEXT: begin
        if (frame_q >= last) begin
          frame_d = loop_q ? '0 : last;
        end else begin
          frame_d = frame_q + 1'b1;
        end
      end
      afs_pkg::CMD_PREV: begin
        if (frame_q == '0) begin
          if (loop_q) begin
            frame_d = last;
          end
        end else begin
          frame_d = frame_q - 1'b1;
        end
      end
      afs_pkg::CMD_START: frame_d = '0;
      afs_pkg::CMD_END:   frame_d = last;
      afs_pkg::CMD_SET:   frame_d = (target_q > last) ? last : target_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= afs_pkg::RESET_INTERVAL;
      count_q     <= FW'(1);
      loop_q      <= 1'b1;
      frame_q     <= '0;
      play_q      <= 1'b0;
      origin_q    <= '0;
      wanted_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          afs_pkg::REG_INTERVAL: interval_q <= cfg_data_i[FW-1:0];
          afs_pkg::REG_COUNT:    count_q    <= cfg_data_i[FW-1:0];
          afs_pkg::REG_LOOP:     loop_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (ctrl_i.commit) begin
        frame_q     <= frame_d;
        play_q      <= play_d;
        origin_q    <= origin_d;
        wanted_q    <= wanted_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q    <= in_cmd_i;
      now_q    <= in_data_i[TW-1:0];
      target_q <= in_data_i[TW+FW-1:TW];
    end
    if (ctrl_i.save_div1) begin
      jump_q      <= div_quo[TW-1:0];
      rem1_q      <= div_rem;
      jump_zero_q <= (div_quo == '0);
      past_q      <= past;
    end
    if (ctrl_i.commit) begin
      out_frame_q <= frame_d;
      out_play_q  <= play_d;
      out_adv_q   <= adv;
      out_chg_q   <= chg;
    end
  end

  assign status_o.tick_play = (cmd_q == afs_pkg::CMD_TICK) && play_q;
  assign status_o.div_done  = div_done;
  assign status_o.need_div2 = !jump_zero_q && past_q && loop_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {5'b0, out_chg_q, out_adv_q, out_play_q, out_frame_q};

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> out_free)
    else $error("result written over an item not yet taken");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_adv_q && out_chg_q))
    else $error("tick advanced and playback changed on one item");

endmodule

// ===== hw/rtl/afs_ctrl.sv =====
module afs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  afs_pkg::dp_status_t  status_i,
  output afs_pkg::ctrl_cmd_t   cmd_o
);

  afs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      afs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = afs_pkg::ST_DECODE;
        end
      end
      afs_pkg::ST_DECODE: begin
        if (status_i.tick_play) begin
          cmd_o.div_start = 1'b1;
          state_d         = afs_pkg::ST_DIV1;
        end else begin
          state_d = afs_pkg::ST_FINISH;
        end
      end
      afs_pkg::ST_DIV1: begin
        if (status_i.div_done) begin
          cmd_o.save_div1 = 1'b1;
          state_d         = afs_pkg::ST_CHECK;
        end
      end
      afs_pkg::ST_CHECK: begin
        // Only a wrap with looping needs the remainder by the frame count.
        if (status_i.need_div2) begin
          cmd_o.div_start     = 1'b1;
          cmd_o.div_sel_count = 1'b1;
          state_d             = afs_pkg::ST_DIV2;
        end else begin
          state_d = afs_pkg::ST_FINISH;
        end
      end
      afs_pkg::ST_DIV2: begin
        if (status_i.div_done) begin
          state_d = afs_pkg::ST_FINISH;
        end
      end
      afs_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = afs_pkg::ST_IDLE;
        end
      end
      default: state_d = afs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/animation_frame_sequencer_top.sv =====
// Channel  Direction  Contents
// s_*      in         tuser: cmd[3:0]; tdata: now_ms[31:0], target_frame[47:32]
// m_*      out        tdata: current_frame[15:0], playing, tick_advanced, play_changed
// cfg_*    in         index 0 frame_interval, 1 frame_count, 2 loop_enable
//
// Non-tick commands and ticks while stopped go from decode to finish, which waits
// for a free output register. A playing tick runs the shared 33-step divider once
// for frame intervals passed, and again on a looping wrap modulo the frame count.
// One item is in work at a time; the next is accepted once the result is written
// to the output register, which holds it until m_tready.
// Reset is asynchronous, active low, and restores the register reset values.
module animation_frame_sequencer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [afs_pkg::IN_DATA_W-1:0]      s_tdata,  // now_ms, target_frame
  input  logic [afs_pkg::CMD_W-1:0]          s_tuser,  // cmd
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [afs_pkg::OUT_DATA_W-1:0]     m_tdata,  // current_frame, playing,
                                                       // tick_advanced, play_changed
  input  logic                               cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [afs_pkg::CFG_W-1:0]          cfg_data_i
);

  afs_pkg::ctrl_cmd_t  ctrl_cmd;
  afs_pkg::dp_status_t dp_status;

  afs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  afs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_tdata),
    .in_cmd_i    (s_tuser),
    .out_ready_i (m_tready),
    .out_valid_o (m_tvalid),
    .out_data_o  (m_tdata),
    .ctrl_i      (ctrl_cmd),
    .status_o    (dp_status)
  );

endmodule

// ===== tb/animation_frame_sequencer_top_tb.sv =====
module animation_frame_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 103;
  localparam int unsigned LONG_HOLD = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               playing;
    logic               advanced;
    logic               changed;
  } frame_result_t;

  typedef struct packed {
    bit                 is_reg;
    cfg_reg_e           reg_sel;
    logic [CFG_W-1:0]   reg_val;
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  now;
    logic [FRAME_W-1:0] tgt;
    bit                 typed;
    frame_result_t      want;
  } script_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;  // now_ms[31:0], target_frame[47:32]
  logic [CMD_W-1:0]      s_tuser;  // cmd[3:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // current_frame[15:0], playing, tick_advanced,
                                   // play_changed
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  // Model of the sequencer state and its registers.
  logic [FRAME_W-1:0] seq_frame;
  logic               seq_playing;
  logic [TIME_W-1:0]  seq_origin;
  logic [TIME_W-1:0]  seq_sched;
  logic [CFG_W-1:0]   cfg_interval;
  logic [CFG_W-1:0]   cfg_count;
  logic               cfg_loop;

  frame_result_t pending_frames[$];
  script_row_t   script[$];
  int            send_calm;
  int            recv_calm;
  int            fail_count;
  bit            hold_req;
  int unsigned   cycle_count;

  animation_frame_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void begin_playback(logic [TIME_W-1:0] now);
    logic [FRAME_W-1:0] last;
    last = (cfg_count == '0) ? '0 : cfg_count - 1'b1;
    if (seq_frame == last) seq_frame = '0;
    seq_playing = 1'b1;
    seq_origin = now;
    seq_sched = '0;
  endfunction

  function automatic frame_result_t advance_sequencer(logic [CMD_W-1:0] cmd,
                                                      logic [TIME_W-1:0] now,
                                                      logic [FRAME_W-1:0] tgt);
    frame_result_t      r;
    logic [FRAME_W-1:0] last;
    logic [63:0]        cnt64, frm64, ivl64, jmp64;
    logic [TIME_W-1:0]  delta;
    bit                 past;
    r = '0;
    cnt64 = (cfg_count == '0) ? 64'd1 : 64'(cfg_count);
    last = FRAME_W'(cnt64 - 1);
    case (cmd)
      CMD_TICK: begin
        if (seq_playing) begin
          ivl64 = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
          delta = now - seq_origin - seq_sched;
          jmp64 = 64'(delta) / ivl64;
          frm64 = 64'(seq_frame);
          if (jmp64 != 0) begin
            past = (frm64 >= cnt64) || (jmp64 >= cnt64 - frm64);
            if (past && !cfg_loop) begin
              seq_playing = 1'b0;
              r.changed = 1'b1;
            end else begin
              if (past) seq_frame = FRAME_W'(((frm64 % cnt64) + (jmp64 % cnt64)) % cnt64);
              else seq_frame = FRAME_W'(frm64 + jmp64);
              r.advanced = 1'b1;
              seq_sched = seq_sched + TIME_W'(jmp64 * ivl64);
            end
          end
        end
      end
      CMD_PLAY: begin
        if (!seq_playing) begin
          begin_playback(now);
          r.changed = 1'b1;
        end
      end
      CMD_STOP: begin
        if (seq_playing) begin
          seq_playing = 1'b0;
          r.changed = 1'b1;
        end
      end
      CMD_TOGGLE: begin
        if (seq_playing) seq_playing = 1'b0;
        else begin_playback(now);
        r.changed = 1'b1;
      end
      CMD_NEXT: begin
        if (seq_frame >= last) seq_frame = cfg_loop ? '0 : last;
        else seq_frame = seq_frame + 1'b1;
      end
      CMD_PREV: begin
        if (seq_frame == '0) begin
          if (cfg_loop) seq_frame = last;
        end else begin
          seq_frame = seq_frame - 1'b1;
        end
      end
      CMD_START: seq_frame = '0;
      CMD_END:   seq_frame = last;
      CMD_SET:   seq_frame = (tgt > last) ? last : tgt;
      default: ;
    endcase
    r.frame = seq_frame;
    r.playing = seq_playing;
    return r;
  endfunction

  // A quiet stretch of several back-to-back items is mixed in now and then.
  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 15);
    end
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                           input logic [FRAME_W-1:0] tgt, input bit typed,
                           input frame_result_t want);
    int            gap;
    frame_result_t calc;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {tgt, now};
    do @(posedge clk_i); while (!s_tready);
    calc = advance_sequencer(cmd, now, tgt);
    pending_frames.push_back(typed ? want : calc);
  endtask

  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apply_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_INTERVAL: cfg_interval = val;
      REG_COUNT:    cfg_count = val;
      REG_LOOP:     cfg_loop = val[0];
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] n,
                          input logic [FRAME_W-1:0] t);
    script_row_t row;
    row = '0;
    row.cmd = c;
    row.now = n;
    row.tgt = t;
    script.push_back(row);
  endtask

  task automatic add_typed(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] n,
                           input logic [FRAME_W-1:0] t, input logic [FRAME_W-1:0] f,
                           input bit p, input bit a, input bit ch);
    script_row_t row;
    row = '0;
    row.cmd = c;
    row.now = n;
    row.tgt = t;
    row.typed = 1'b1;
    row.want.frame = f;
    row.want.playing = p;
    row.want.advanced = a;
    row.want.changed = ch;
    script.push_back(row);
  endtask

  task automatic add_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    script_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_sel = idx;
    row.reg_val = val;
    script.push_back(row);
  endtask

  initial begin : result_sink
    int            stall;
    frame_result_t want;
    frame_result_t got;
    m_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      draw_wait(recv_calm, stall);
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      got.frame = m_tdata[15:0];
      got.playing = m_tdata[16];
      got.advanced = m_tdata[17];
      got.changed = m_tdata[18];
      if (pending_frames.size() == 0) begin
        $error("result item with nothing outstanding: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (got.frame !== want.frame) begin
          $error("current_frame: expected %0d, actual %0d", want.frame, got.frame);
          fail_count++;
        end
        if (got.playing !== want.playing) begin
          $error("playing: expected %0b, actual %0b", want.playing, got.playing);
          fail_count++;
        end
        if (got.advanced !== want.advanced) begin
          $error("tick_advanced: expected %0b, actual %0b", want.advanced, got.advanced);
          fail_count++;
        end
        if (got.changed !== want.changed) begin
          $error("play_changed: expected %0b, actual %0b", want.changed, got.changed);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    script_row_t        row;
    int                 ph, k, pick;
    logic [63:0]        ivl64, cnt64, step;
    logic [TIME_W-1:0]  clock_ms;
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] tgt, last;
    logic [CFG_W-1:0]   p_ivl, p_cnt;
    bit                 p_loop;

    rst_ni <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_INTERVAL;
    cfg_data_i <= '0;
    seq_frame = '0;
    seq_playing = 1'b0;
    seq_origin = '0;
    seq_sched = '0;
    cfg_interval = RESET_INTERVAL;
    cfg_count = 16'd1;
    cfg_loop = 1'b1;
    send_calm = 0;
    recv_calm = 0;
    fail_count = 0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset settings.
    add_typed(CMD_TICK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_STOP, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0);
    add_reg(REG_COUNT, 16'hFFFF);
    add_reg(REG_INTERVAL, 16'h0000);
    add_reg(REG_LOOP, 16'd0);
    add_typed(CMD_SET, 32'd5, 16'hFFFF, 16'd65534, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_NEXT, 32'd6, 16'd0, 16'd65534, 1'b0, 1'b0, 1'b0);
    // Play from the last frame rewinds to frame zero.
    add_typed(CMD_PLAY, 32'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
    add_typed(CMD_PLAY, 32'd200, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    // Runs past the end without looping, so playback stops.
    add_typed(CMD_TICK, 32'd65635, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    add_typed(CMD_TOGGLE, 32'hFFFF_FFF0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
    // The timestamp wraps between the start and this tick.
    add_typed(CMD_TICK, 32'h0000_0010, 16'd0, 16'd32, 1'b1, 1'b1, 1'b0);
    add_item(CMD_TICK, 32'h0000_0010, 16'd7);
    add_item(CMD_TOGGLE, 32'h8000_0000, 16'h8000);
    add_item(CMD_PREV, 32'h7FFF_FFFF, 16'h7FFF);
    add_typed(CMD_START, 32'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_PREV, 32'd2, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_reg(REG_LOOP, 16'd1);
    add_typed(CMD_PREV, 32'd3, 16'd0, 16'd65534, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_NEXT, 32'd4, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_END, 32'd5, 16'd0, 16'd65534, 1'b0, 1'b0, 1'b0);
    // A zero count leaves the frame far beyond the end; the next tick wraps it.
    add_reg(REG_COUNT, 16'd0);
    add_reg(REG_INTERVAL, 16'hFFFF);
    add_item(CMD_PLAY, 32'd0, 16'd0);
    add_item(CMD_TICK, 32'd65535, 16'd0);
    add_item(CMD_TICK, 32'd131070, 16'd0);
    add_typed(CMD_STOP, 32'd131071, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    add_item(CMD_UNUSED_LO, 32'd131072, 16'd3);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) begin
        drain(4);
        apply_reg(row.reg_sel, row.reg_val);
      end else begin
        send_item(row.cmd, row.now, row.tgt, row.typed, row.want);
      end
    end

    clock_ms = $urandom();
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin p_ivl = 16'd1;     p_cnt = 16'hFFFF; p_loop = 1'b1; end
        1: begin p_ivl = 16'hFFFF;  p_cnt = 16'd2;    p_loop = 1'b0; end
        2: begin p_ivl = 16'd0;     p_cnt = 16'd0;    p_loop = 1'b1; end
        3: begin p_ivl = 16'd83;    p_cnt = 16'd24;   p_loop = 1'b1; end
        PHASES - 1: begin p_ivl = 16'hFFFF; p_cnt = 16'hFFFF; p_loop = 1'b0; end
        default: begin
          p_ivl = $urandom_range(0, 1) ? 16'($urandom_range(1, 16)) : 16'($urandom());
          p_cnt = $urandom_range(0, 1) ? 16'($urandom_range(1, 12)) : 16'($urandom());
          p_loop = $urandom_range(0, 1);
        end
      endcase
      drain(4);
      apply_reg(REG_INTERVAL, p_ivl);
      apply_reg(REG_COUNT, p_cnt);
      apply_reg(REG_LOOP, {15'd0, p_loop});
      // The sink holds off for a long stretch so the block backs up its input.
      if (ph == 3) hold_req = 1'b1;
      ivl64 = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
      cnt64 = (cfg_count == '0) ? 64'd1 : 64'(cfg_count);
      last = FRAME_W'(cnt64 - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) step = 64'($urandom_range(0, 32'(3 * ivl64)));
        else if (pick < 85) step = ivl64 * $urandom_range(0, 32'(2 * cnt64 + 2))
                                   + $urandom_range(0, 3);
        else if (pick < 95) step = 64'($urandom());
        else step = 64'd0;
        clock_ms = clock_ms + step[TIME_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = CMD_TICK;
        else if (pick < 52) cmd = CMD_PLAY;
        else if (pick < 58) cmd = CMD_STOP;
        else if (pick < 64) cmd = CMD_TOGGLE;
        else if (pick < 71) cmd = CMD_NEXT;
        else if (pick < 78) cmd = CMD_PREV;
        else if (pick < 83) cmd = CMD_START;
        else if (pick < 88) cmd = CMD_END;
        else if (pick < 95) cmd = CMD_SET;
        else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        tgt = $urandom_range(0, 1) ? FRAME_W'($urandom_range(0, last))
                                   : FRAME_W'($urandom());
        send_item(cmd, clock_ms, tgt, 1'b0, '0);
      end
    end

    drain(120);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
